// File: design/proximity_graph_edge_finder_macros.svh
// Assertion macros shared by the edge finder
`ifndef PROXIMITY_GRAPH_EDGE_FINDER_MACROS_SVH
`define PROXIMITY_GRAPH_EDGE_FINDER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PGEF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PGEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/pgef_pkg.sv
// Types and constants of the proximity graph edge finder
`timescale 1ns / 1ps

package pgef_pkg;

    localparam int ID_W    = 16;
    localparam int COORD_W = 16;
    localparam int DIST_W  = 17;
    localparam int DIFF_W  = COORD_W;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int SUM_W   = SQ_W + 1;
    localparam int RSQ_W   = 2 * DIST_W;

    localparam logic [DIST_W-1:0] RADIUS_RESET = 17'd10;
    localparam logic [RSQ_W-1:0]  RSQ_RESET    = 34'd100;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
        logic [ID_W-1:0]           id;
    } robot_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [ID_W-1:0]   id_b;
        logic [ID_W-1:0]   id_a;
    } edge_t;

    localparam int IN_TDATA_W  = $bits(robot_t);
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - $bits(edge_t);

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIST_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// File: design/proximity_graph_edge_finder.sv
// Top level of the proximity graph edge finder
//
// Slave channel s_*: one robot per transfer; s_tuser restarts the set.
// Master channel m_*: one edge per transfer; m_tlast marks the last edge
// of a robot. A robot that finds no neighbour in range gives no transfer.
// cfg_we / cfg_wdata write the radius; write only while the block is idle.
// The front end takes a robot into a two-entry queue; s_tready drops only
// while that queue is full. The back end serves one robot at a time: it
// steps through the read, square and compare states for each stored robot,
// through the bit-serial square root and hand-off for each edge, and through
// fetch, flush and store once per robot; an empty set skips the scan and the
// flush. The square root unit sets the edge rate. Each edge leaves one edge
// later than found, so that the last one can carry m_tlast. A robot arriving
// with the set full is dropped.
// Reset empties the set and the queue and sets the radius to 10.
// A stalled master side holds the output register and backs up the queue.
`timescale 1ns / 1ps
`include "proximity_graph_edge_finder_macros.svh"

module proximity_graph_edge_finder #(
    parameter int MAX_ROBOTS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pgef_pkg::IN_TDATA_W-1:0]     s_tdata,   // robot_id, x_coord, y_coord
    input  logic                                s_tuser,   // start_new
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pgef_pkg::OUT_TDATA_W-1:0]    m_tdata,   // id_a, id_b, distance, zero pad
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [pgef_pkg::DIST_W-1:0]         cfg_wdata
);

    import pgef_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROBOTS + 1);
    localparam int AW    = $clog2(MAX_ROBOTS);
    localparam int Q_W   = $bits(robot_t) + CNT_W;

    logic [DIST_W-1:0] radius_reg;
    logic [RSQ_W-1:0]  rsq_reg;

    logic              q_push;
    robot_t            push_robot;
    logic [CNT_W-1:0]  push_slot;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    logic [Q_W-1:0]    q_data;
    robot_t            q_robot;
    logic [CNT_W-1:0]  q_slot;

    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    robot_t            ram_rdata;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    robot_t            ram_wdata;

    sqrt_req_t         sqrt_req;
    sqrt_rsp_t         sqrt_rsp;
    edge_t             out_edge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            rsq_reg    <= RSQ_RESET;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_wdata;
            rsq_reg    <= RSQ_W'(cfg_wdata) * RSQ_W'(cfg_wdata);
        end
    end

    pgef_front #(
        .MAX_ROBOTS (MAX_ROBOTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .start_new  (s_tuser),
        .robot      (robot_t'(s_tdata)),
        .q_full     (q_full),
        .push       (q_push),
        .push_robot (push_robot),
        .push_slot  (push_slot)
    );

    pgef_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_robot, push_slot}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .valid     (q_valid)
    );

    assign q_robot = robot_t'(q_data[Q_W-1:CNT_W]);
    assign q_slot  = q_data[CNT_W-1:0];

    pgef_ram #(
        .WIDTH ($bits(robot_t)),
        .DEPTH (MAX_ROBOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pgef_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    pgef_back #(
        .MAX_ROBOTS (MAX_ROBOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_robot   (q_robot),
        .q_slot    (q_slot),
        .rsq       (rsq_reg),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .sqrt_req  (sqrt_req),
        .sqrt_rsp  (sqrt_rsp),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_edge    (out_edge),
        .m_last    (m_tlast)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_edge};

    `PGEF_ASSERT_SAME(a_dist_below_radius, m_tvalid, out_edge.distance < radius_reg, "edge distance not below radius")
    `PGEF_ASSERT_SAME(a_slot_in_range, q_push, push_slot < CNT_W'(MAX_ROBOTS), "robot slot beyond capacity")
    `PGEF_ASSERT_SAME(a_root_not_restarted, sqrt_req.start, !sqrt_rsp.busy, "square root restarted while busy")
    `PGEF_ASSERT_NEXT(a_root_starts, sqrt_req.start, sqrt_rsp.busy, "square root did not start")

endmodule

// File: design/pgef_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps

module pgef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/pgef_front.sv
// Front end: accept robots, apply set restart and capacity, assign slots
`timescale 1ns / 1ps

module pgef_front #(
    parameter int MAX_ROBOTS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              start_new,
    input  pgef_pkg::robot_t                  robot,
    input  logic                              q_full,
    output logic                              push,
    output pgef_pkg::robot_t                  push_robot,
    output logic [$clog2(MAX_ROBOTS+1)-1:0]   push_slot
);

    import pgef_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROBOTS + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] base;
    logic             accept;

    assign s_ready    = ~q_full;
    assign accept     = s_valid & ~q_full;
    assign base       = start_new ? '0 : count_reg;
    assign push       = accept & (base < CNT_W'(MAX_ROBOTS));
    assign push_robot = robot;
    assign push_slot  = base;
    assign count_next = push ? base + CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: design/pgef_queue.sv
// Short FIFO between the front and back ends
`timescale 1ns / 1ps

module pgef_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             valid
);

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [FW-1:0]    fill_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = (fill_reg == FW'(DEPTH));
    assign valid    = (fill_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push & ~full;
    assign do_pop   = pop & valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push & ~do_pop)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            else if (do_pop & ~do_push)
            begin
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

endmodule

// File: design/pgef_isqrt.sv
// Bit-serial integer square root, one result bit per cycle
`timescale 1ns / 1ps

module pgef_isqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  pgef_pkg::sqrt_req_t req,
    output pgef_pkg::sqrt_rsp_t rsp
);

    import pgef_pkg::*;

    localparam int PAD_W  = 2 * DIST_W;
    localparam int REM_W  = DIST_W + 2;
    localparam int SH_W   = DIST_W + 4;
    localparam int STEP_W = $clog2(DIST_W);

    logic              run_reg;
    logic              done_reg;
    logic [PAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [DIST_W-1:0] root_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SH_W-1:0]   rem_sh;
    logic [SH_W-1:0]   trial;
    logic [SH_W-1:0]   rem_sub;
    logic              ge;

    assign rem_sh  = {rem_reg, rad_reg[PAD_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_sub = rem_sh - trial;

    assign rsp.busy = run_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (run_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIST_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (req.start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[DIST_W-2:0], ge};
        end
        else if (req.start)
        begin
            rad_reg  <= PAD_W'(req.value);
            rem_reg  <= '0;
            root_reg <= '0;
        end
    end

endmodule

// File: design/pgef_back.sv
// Back end: scan stored robots, test range, take roots, emit edges, store robot
`timescale 1ns / 1ps

module pgef_back #(
    parameter int MAX_ROBOTS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    output logic                              q_pop,
    input  pgef_pkg::robot_t                  q_robot,
    input  logic [$clog2(MAX_ROBOTS+1)-1:0]   q_slot,
    input  logic [pgef_pkg::RSQ_W-1:0]        rsq,
    output logic                              ram_re,
    output logic [$clog2(MAX_ROBOTS)-1:0]     ram_raddr,
    input  pgef_pkg::robot_t                  ram_rdata,
    output logic                              ram_we,
    output logic [$clog2(MAX_ROBOTS)-1:0]     ram_waddr,
    output pgef_pkg::robot_t                  ram_wdata,
    output pgef_pkg::sqrt_req_t               sqrt_req,
    input  pgef_pkg::sqrt_rsp_t               sqrt_rsp,
    output logic                              m_valid,
    input  logic                              m_ready,
    output pgef_pkg::edge_t                   m_edge,
    output logic                              m_last
);

    import pgef_pkg::*;

    localparam int CNT_W = $clog2(MAX_ROBOTS + 1);
    localparam int AW    = $clog2(MAX_ROBOTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQUARE,
        ST_TEST,
        ST_ROOT,
        ST_EMIT,
        ST_FLUSH,
        ST_STORE
    } state_t;

    state_t            state_reg,     state_next;
    robot_t            cur_reg,       cur_next;
    logic [CNT_W-1:0]  n_reg,         n_next;
    logic [CNT_W-1:0]  idx_reg,       idx_next;
    logic [ID_W-1:0]   cand_id_reg,   cand_id_next;
    logic [SQ_W-1:0]   dx2_reg,       dx2_next;
    logic [SQ_W-1:0]   dy2_reg,       dy2_next;
    logic [DIST_W-1:0] new_dist_reg,  new_dist_next;
    logic              pend_valid_reg, pend_valid_next;
    edge_t             pend_reg,      pend_next;
    logic              out_valid_reg, out_valid_next;
    edge_t             out_reg,       out_next;
    logic              out_last_reg,  out_last_next;

    logic signed [COORD_W:0] dxs;
    logic signed [COORD_W:0] dys;
    logic [DIFF_W-1:0]       dxa;
    logic [DIFF_W-1:0]       dya;
    logic [SUM_W-1:0]        sum;
    logic                    out_free;
    logic                    at_end;
    edge_t                   new_edge;

    assign dxs = $signed({cur_reg.x[COORD_W-1], cur_reg.x})
               - $signed({ram_rdata.x[COORD_W-1], ram_rdata.x});
    assign dys = $signed({cur_reg.y[COORD_W-1], cur_reg.y})
               - $signed({ram_rdata.y[COORD_W-1], ram_rdata.y});
    assign dxa = dxs[COORD_W] ? DIFF_W'(-dxs) : DIFF_W'(dxs);
    assign dya = dys[COORD_W] ? DIFF_W'(-dys) : DIFF_W'(dys);
    assign sum = SUM_W'(dx2_reg) + SUM_W'(dy2_reg);

    assign out_free = ~out_valid_reg | m_ready;
    assign at_end   = (idx_reg + CNT_W'(1) == n_reg);

    assign new_edge.id_a     = cand_id_reg;
    assign new_edge.id_b     = cur_reg.id;
    assign new_edge.distance = new_dist_reg;

    assign ram_raddr = idx_reg[AW-1:0];
    assign ram_waddr = n_reg[AW-1:0];
    assign ram_wdata = cur_reg;

    assign m_valid = out_valid_reg;
    assign m_edge  = out_reg;
    assign m_last  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        n_next          = n_reg;
        idx_next        = idx_reg;
        cand_id_next    = cand_id_reg;
        dx2_next        = dx2_reg;
        dy2_next        = dy2_reg;
        new_dist_next   = new_dist_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg & ~m_ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        ram_re          = 1'b0;
        ram_we          = 1'b0;
        sqrt_req.start  = 1'b0;
        sqrt_req.value  = sum;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_robot;
                    n_next     = q_slot;
                    idx_next   = '0;
                    state_next = (q_slot == '0) ? ST_STORE : ST_READ;
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cand_id_next = ram_rdata.id;
                dx2_next     = SQ_W'(dxa) * SQ_W'(dxa);
                dy2_next     = SQ_W'(dya) * SQ_W'(dya);
                state_next   = ST_TEST;
            end
            ST_TEST:
            begin
                if (RSQ_W'(sum) < rsq)
                begin
                    sqrt_req.start = 1'b1;
                    state_next     = ST_ROOT;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = at_end ? ST_FLUSH : ST_READ;
                end
            end
            ST_ROOT:
            begin
                if (sqrt_rsp.done)
                begin
                    new_dist_next = sqrt_rsp.root;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = new_edge;
                    idx_next        = idx_reg + CNT_W'(1);
                    state_next      = at_end ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_STORE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_STORE;
                end
            end
            ST_STORE:
            begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        cand_id_reg  <= cand_id_next;
        dx2_reg      <= dx2_next;
        dy2_reg      <= dy2_next;
        new_dist_reg <= new_dist_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

endmodule

// File: dv/proximity_graph_edge_finder_checker.sv
// Edge predictor and scoreboard for the proximity graph edge finder
`timescale 1ns / 1ps

module proximity_graph_edge_finder_checker #(
    parameter int MAX_ROBOTS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [pgef_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [pgef_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [pgef_pkg::DIST_W-1:0]      cfg_wdata,
    output int                               fail_count,
    output int                               pending_edges,
    output int                               edges_checked,
    output int                               robots_taken,
    output int                               robots_dropped
);

    import pgef_pkg::*;

    typedef struct {
        logic [ID_W-1:0]   id_a;
        logic [ID_W-1:0]   id_b;
        logic [DIST_W-1:0] distance;
        logic              last;
    } edge_exp_t;

    localparam int EDGE_W = $bits(edge_t);

    edge_exp_t                 edge_q[$];
    logic [ID_W-1:0]           set_id [MAX_ROBOTS];
    logic signed [COORD_W-1:0] set_x  [MAX_ROBOTS];
    logic signed [COORD_W-1:0] set_y  [MAX_ROBOTS];
    int                        set_size;
    logic [DIST_W-1:0]         radius;

    function automatic logic [DIST_W-1:0] floor_root(longint sq);
        logic [DIST_W-1:0] root;
        logic [DIST_W-1:0] trial;
        longint            t;
        root = '0;
        for (int b = DIST_W - 1; b >= 0; b--)
        begin
            trial = root | (DIST_W'(1) << b);
            t = longint'(trial);
            if (t * t <= sq)
                root = trial;
        end
        return root;
    endfunction

    task automatic add_robot(input logic start, input robot_t rb);
        int                first;
        longint            dx;
        longint            dy;
        logic [DIST_W-1:0] d;
        edge_exp_t         e;
        if (start)
            set_size = 0;
        if (set_size >= MAX_ROBOTS)
        begin
            robots_dropped++;
            return;
        end
        first = edge_q.size();
        for (int i = 0; i < set_size; i++)
        begin
            dx = longint'(rb.x) - longint'(set_x[i]);
            dy = longint'(rb.y) - longint'(set_y[i]);
            d  = floor_root(dx * dx + dy * dy);
            if (d < radius)
            begin
                e.id_a     = set_id[i];
                e.id_b     = rb.id;
                e.distance = d;
                e.last     = 1'b0;
                edge_q.push_back(e);
            end
        end
        if (edge_q.size() > first)
            edge_q[edge_q.size() - 1].last = 1'b1;
        set_id[set_size] = rb.id;
        set_x[set_size]  = rb.x;
        set_y[set_size]  = rb.y;
        set_size++;
        robots_taken++;
    endtask

    always @(posedge clk)
    begin : watch
        edge_t     got;
        edge_exp_t want;
        if (!rst_n)
        begin
            edge_q.delete();
            set_size      = 0;
            radius        = RADIUS_RESET;
            pending_edges = 0;
        end
        else
        begin
            if (cfg_we)
                radius = cfg_wdata;
            if (s_tvalid && s_tready)
                add_robot(s_tuser, robot_t'(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = edge_t'(m_tdata[EDGE_W-1:0]);
                if (edge_q.size() == 0)
                begin
                    $display("%0t: edge with none expected: id_a=%h id_b=%h dist=%0d last=%b",
                             $time, got.id_a, got.id_b, got.distance, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = edge_q.pop_front();
                    edges_checked++;
                    if (got.id_a !== want.id_a || got.id_b !== want.id_b ||
                        got.distance !== want.distance || m_tlast !== want.last ||
                        m_tdata[OUT_TDATA_W-1:EDGE_W] !== '0)
                    begin
                        $display("%0t: edge mismatch: expected id_a=%h id_b=%h dist=%0d last=%b",
                                 $time, want.id_a, want.id_b, want.distance, want.last);
                        $display("%0t:                actual id_a=%h id_b=%h dist=%0d last=%b pad=%h",
                                 $time, got.id_a, got.id_b, got.distance, m_tlast,
                                 m_tdata[OUT_TDATA_W-1:EDGE_W]);
                        fail_count++;
                    end
                end
            end
            pending_edges = edge_q.size();
        end
    end

endmodule

// File: dv/proximity_graph_edge_finder_tb.sv
// Stimulus and verdict for the proximity graph edge finder
`timescale 1ns / 1ps

module proximity_graph_edge_finder_tb;

    import pgef_pkg::*;

    localparam int MAX_ROBOTS   = 32;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 400;
    localparam logic [DIST_W-1:0] RADIUS_MAX = 17'd131071;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tuser   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [DIST_W-1:0]      cfg_wdata = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int fail_count;
    int pending_edges;
    int edges_checked;
    int robots_taken;
    int robots_dropped;
    int radius_settings = 0;
    bit src_calm  = 1'b0;
    bit sink_calm = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    proximity_graph_edge_finder #(
        .MAX_ROBOTS (MAX_ROBOTS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    proximity_graph_edge_finder_checker #(
        .MAX_ROBOTS (MAX_ROBOTS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .fail_count     (fail_count),
        .pending_edges  (pending_edges),
        .edges_checked  (edges_checked),
        .robots_taken   (robots_taken),
        .robots_dropped (robots_dropped)
    );

    function automatic int idle_gap();
        int r;
        if (src_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(
        input logic signed [COORD_W-1:0] centre,
        input int                        spread
    );
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 80)
        begin
            v = int'(centre) + int'($urandom_range(0, 2 * spread)) - spread;
            return v[COORD_W-1:0];
        end
        if (r < 90)
            return COORD_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            default: return -16'sd1;
        endcase
    endfunction

    // Call at a falling edge; returns at the falling edge after the transfer
    task automatic send_robot(
        input logic                      start,
        input logic [ID_W-1:0]           id,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y
    );
        int gap;
        gap = idle_gap();
        repeat (gap) @(negedge clk);
        s_tdata  = {y, x, id};
        s_tuser  = start;
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending_edges != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_radius(input logic [DIST_W-1:0] value);
        drain();
        cfg_wdata = value;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
        radius_settings++;
    endtask

    task automatic run_random(input int items, input logic [DIST_W-1:0] rad);
        int                        done;
        int                        in_set;
        int                        set_len;
        int                        spread;
        int                        r;
        logic                      start;
        logic [ID_W-1:0]           id;
        logic [ID_W-1:0]           prev_id;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] prev_x;
        logic signed [COORD_W-1:0] prev_y;
        done    = 0;
        in_set  = 0;
        prev_id = '0;
        prev_x  = '0;
        prev_y  = '0;
        spread  = (rad < 2) ? 2 : ((rad > 20000) ? 20000 : int'(rad));
        while (done < items)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
                set_len = $urandom_range(1, 10);
            else if (r < 95)
                set_len = $urandom_range(11, 24);
            else
                set_len = $urandom_range(30, 38);
            cx = COORD_W'($urandom);
            cy = COORD_W'($urandom);
            for (int k = 0; k < set_len && done < items; k++)
            begin
                start = (k == 0) || ($urandom_range(0, 99) < 2);
                id    = ID_W'($urandom);
                x     = pick_coord(cx, spread);
                y     = pick_coord(cy, spread);
                if (k > 0 && $urandom_range(0, 19) == 0)
                    id = prev_id;
                if (k > 0 && $urandom_range(0, 19) == 0)
                begin
                    x = prev_x;
                    y = prev_y;
                end
                send_robot(start, id, x, y);
                if (start)
                    in_set = 0;
                if (in_set < MAX_ROBOTS)
                begin
                    in_set++;
                    done++;
                end
                prev_id = id;
                prev_x  = x;
                prev_y  = y;
            end
        end
    endtask

    initial
    begin : sink
        int hold;
        int r;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (sink_calm || $urandom_range(0, 99) < 65)
            begin
                m_tready = 1'b1;
                hold     = $urandom_range(1, 12);
            end
            else
            begin
                m_tready = 1'b0;
                r        = $urandom_range(0, 99);
                if (r < 80)
                    hold = $urandom_range(1, 3);
                else if (r < 95)
                    hold = $urandom_range(4, 12);
                else
                    hold = $urandom_range(30, 100);
            end
        end
    end

    initial
    begin : calm_stretches
        forever
        begin
            repeat ($urandom_range(200, 1500)) @(negedge clk);
            src_calm  = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin : watchdog
        #60_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [DIST_W-1:0] phase_radius [5];
        phase_radius[0] = DIST_W'($urandom_range(3, 40));
        phase_radius[1] = RADIUS_MAX;
        phase_radius[2] = 17'd1;
        phase_radius[3] = DIST_W'($urandom_range(100, 3000));
        phase_radius[4] = DIST_W'($urandom_range(0, 131071));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset radius: near pairs, a pair exactly at the radius, equal id and position
        send_robot(1'b1, 16'd1, 16'sd0, 16'sd0);
        send_robot(1'b0, 16'd2, 16'sd3, 16'sd4);
        send_robot(1'b0, 16'd3, 16'sd0, 16'sd10);
        send_robot(1'b0, 16'd3, 16'sd0, 16'sd10);
        send_robot(1'b0, 16'd0, 16'sd7, 16'sd7);
        send_robot(1'b1, 16'hFFFF, -16'sd1, -16'sd1);
        send_robot(1'b0, 16'h0000, 16'sd0, 16'sd0);

        // widest radius: corners of the coordinate range
        write_radius(RADIUS_MAX);
        send_robot(1'b1, 16'h0000, 16'sh8000, 16'sh8000);
        send_robot(1'b0, 16'hFFFF, 16'sh7FFF, 16'sh7FFF);
        send_robot(1'b0, 16'hAAAA, 16'sh7FFF, 16'sh8000);
        send_robot(1'b0, 16'h5555, 16'sh8000, 16'sh7FFF);
        send_robot(1'b0, 16'h1234, 16'sd0, 16'sd0);

        // zero radius: no edges at all
        write_radius('0);
        send_robot(1'b1, 16'd5, 16'sd5, 16'sd5);
        send_robot(1'b0, 16'd6, 16'sd5, 16'sd5);
        send_robot(1'b0, 16'd7, 16'sh7FFF, 16'sh8000);

        // unit radius: only coincident robots connect
        write_radius(17'd1);
        send_robot(1'b1, 16'd7, 16'sd100, -16'sd100);
        send_robot(1'b0, 16'd8, 16'sd100, -16'sd100);
        send_robot(1'b0, 16'd9, 16'sd101, -16'sd100);
        send_robot(1'b0, 16'd10, 16'sh8000, 16'sd0);

        // distance equal to radius is excluded
        write_radius(17'd5);
        send_robot(1'b1, 16'd20, 16'sd0, 16'sd0);
        send_robot(1'b0, 16'd21, 16'sd3, 16'sd4);
        send_robot(1'b0, 16'd22, 16'sd2, 16'sd4);

        for (int p = 0; p < 5; p++)
        begin
            write_radius(phase_radius[p]);
            run_random(PHASE_ITEMS, phase_radius[p]);
        end

        drain();
        $display("Run covered %0d stored robots and %0d dropped at capacity,",
                 robots_taken, robots_dropped);
        $display("with %0d edges checked over %0d radius settings.",
                 edges_checked, radius_settings + 1);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/pgef_pkg.sv
design/pgef_ram.sv
design/pgef_front.sv
design/pgef_queue.sv
design/pgef_isqrt.sv
design/pgef_back.sv
design/proximity_graph_edge_finder.sv
dv/proximity_graph_edge_finder_checker.sv
dv/proximity_graph_edge_finder_tb.sv
